// ----- hdl/ffts_pkg.sv -----
package ffts_pkg;

	localparam int NAME_W = 64;
	localparam int SIZE_W = 13;

	localparam logic [2:0] CMD_FORMAT = 3'd0;
	localparam logic [2:0] CMD_CREATE = 3'd1;
	localparam logic [2:0] CMD_DELETE = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_WRITE  = 3'd4;
	localparam logic [2:0] CMD_INFO   = 3'd5;

	localparam logic [2:0] STS_OK            = 3'd0;
	localparam logic [2:0] STS_NOT_MOUNTED   = 3'd1;
	localparam logic [2:0] STS_NO_FREE_COUNT = 3'd2;
	localparam logic [2:0] STS_NO_FREE_ENTRY = 3'd3;
	localparam logic [2:0] STS_NOT_FOUND     = 3'd4;
	localparam logic [2:0] STS_RANGE         = 3'd5;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [63:0] file_name;
		logic [11:0] byte_offset;
		logic [7:0]  write_data;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] read_data;
		logic [8:0] free_count;
		logic [8:0] used_count;
	} out_word_t;

	// Byte-wise compare; a shared terminator ends the name early.
	function automatic logic names_match(input logic [NAME_W-1:0] stored,
			input logic [NAME_W-1:0] given, input int nb);
		logic m;
		logic done;
		logic [7:0] a;
		logic [7:0] b;
		m = 1'b1;
		done = 1'b0;
		for (int j = 0; j < 8; j++) begin
			a = stored[8*j +: 8];
			b = given[8*j +: 8];
			if (j < nb && !done) begin
				if (a != b) begin
					m = 1'b0;
					done = 1'b1;
				end else if (a == 8'd0) begin
					done = 1'b1;
				end
			end
		end
		return m;
	endfunction

	// Keep the name up to its first zero byte, leaving room for a terminator.
	function automatic logic [NAME_W-1:0] store_form(input logic [NAME_W-1:0] given,
			input int nb);
		logic [NAME_W-1:0] res;
		logic stop;
		logic [7:0] b;
		res = '0;
		stop = 1'b0;
		for (int j = 0; j < 7; j++) begin
			b = given[8*j +: 8];
			if (j + 1 < nb && !stop) begin
				if (b == 8'd0) begin
					stop = 1'b1;
				end else begin
					res[8*j +: 8] = b;
				end
			end
		end
		return res;
	endfunction

endpackage

// ----- hdl/ffts_ram.sv -----
module ffts_ram #(
	parameter int W = 8,
	parameter int D = 16,
	localparam int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/flat_file_table_store_top.sv -----
// Flat file table store: one command word in, one result word out. Format,
// info, unknown codes, commands refused before mount and a create with a zero
// free count go straight to the result. Delete, read byte and write byte walk
// the entry table one entry per cycle through the entry memory, and a read
// byte that returns a byte then waits on the data memory read. Create looks
// for the first unused entry and then zeroes that entry's data block through
// the single data memory port, one byte per cycle. Format only clears the
// used marks; a block is cleared when an entry is created. No clearing pass
// runs after reset. A new command is taken while the previous result waits.
module flat_file_table_store_top #(
	parameter int ENTRIES    = 16,
	parameter int NAME_BYTES = 8,
	parameter int FILE_BYTES = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ffts_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ffts_pkg::out_word_t  out_data
);

	import ffts_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int DEPTH = ENTRIES * FILE_BYTES;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(FILE_BYTES + 1);

	typedef struct packed {
		logic [NAME_W-1:0] name;
		logic [SIZE_W-1:0] size;
	} ent_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CLEAR,
		S_RDWAIT,
		S_DONE
	} state_t;

	state_t            state_q;
	logic              mounted_q;
	logic [8:0]        free_q;
	logic [ENTRIES-1:0] used_q;
	logic [IW:0]       scan_q;
	logic              valid_s1;
	logic [IW-1:0]     idx_s1;
	logic [IW-1:0]     hit_idx_q;
	logic [CW-1:0]     clr_q;
	logic              out_valid_q;
	out_word_t         out_q;
	out_word_t         res_q;

	logic [2:0]        cmd_q;
	logic [NAME_W-1:0] name_q;
	logic [11:0]       off_q;
	logic [7:0]        wdata_q;

	ent_t              ent_rd;
	ent_t              ent_wdata;
	logic              ent_we;
	logic [IW-1:0]     ent_waddr;
	logic [IW-1:0]     scan_idx;
	logic              scan_end;

	logic              dat_we;
	logic [AW-1:0]     dat_addr;
	logic [7:0]        dat_wdata;
	logic [7:0]        dat_rd;
	logic [IW-1:0]     dat_idx;
	logic [AW-1:0]     dat_off;

	logic              hit;
	logic              last_s1;
	logic              free_slot;
	logic [SIZE_W-1:0] off_ext;
	logic              off_big;
	logic              off_past;
	logic              is_lookup;
	logic              go_scan;
	logic [2:0]        idle_status;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		scan_idx  = scan_q[IW-1:0];
		scan_end  = (scan_q == (IW+1)'(ENTRIES));
		is_lookup = (cmd_q == CMD_DELETE) || (cmd_q == CMD_READ) || (cmd_q == CMD_WRITE);
		off_ext   = {1'b0, off_q};
		off_big   = off_ext >= SIZE_W'(FILE_BYTES);
		off_past  = off_ext >= ent_rd.size;
		last_s1   = (idx_s1 == IW'(ENTRIES - 1));
		hit = (state_q == S_SCAN) && is_lookup && valid_s1 && used_q[idx_s1]
			&& names_match(ent_rd.name, name_q, NAME_BYTES);
		free_slot = (state_q == S_SCAN) && (cmd_q == CMD_CREATE) && !scan_end
			&& !used_q[scan_idx];

		ent_we    = free_slot || (hit && (cmd_q == CMD_WRITE) && !off_big);
		ent_waddr = free_slot ? scan_idx : idx_s1;
		if (free_slot) begin
			ent_wdata = '{name: store_form(name_q, NAME_BYTES), size: '0};
		end else begin
			ent_wdata = '{name: ent_rd.name,
				size: off_past ? off_ext + SIZE_W'(1) : ent_rd.size};
		end

		dat_idx   = (state_q == S_CLEAR) ? hit_idx_q : idx_s1;
		dat_off   = (state_q == S_CLEAR) ? AW'(clr_q) : AW'(off_q);
		dat_addr  = AW'(dat_idx) * AW'(FILE_BYTES) + dat_off;
		dat_we    = (state_q == S_CLEAR) || (hit && (cmd_q == CMD_WRITE) && !off_big);
		dat_wdata = (state_q == S_CLEAR) ? 8'd0 : wdata_q;
	end

	// Decision made when a word is taken in the idle state.
	always_comb begin
		go_scan = 1'b0;
		priority if (in_data.cmd == CMD_FORMAT) begin
			idle_status = STS_OK;
		end else if (in_data.cmd > CMD_INFO) begin
			idle_status = STS_OK;
		end else if (!mounted_q) begin
			idle_status = STS_NOT_MOUNTED;
		end else if (in_data.cmd == CMD_CREATE && free_q == 9'd0) begin
			idle_status = STS_NO_FREE_COUNT;
		end else begin
			idle_status = STS_OK;
			go_scan = (in_data.cmd != CMD_INFO);
		end
	end

	ffts_ram #(.W(NAME_W + SIZE_W), .D(ENTRIES)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (scan_idx),
		.rdata (ent_rd)
	);

	ffts_ram #(.W(8), .D(DEPTH)) u_dat_ram (
		.clk   (clk),
		.we    (dat_we),
		.waddr (dat_addr),
		.wdata (dat_wdata),
		.raddr (dat_addr),
		.rdata (dat_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mounted_q   <= 1'b0;
			free_q      <= '0;
			used_q      <= '0;
			scan_q      <= '0;
			valid_s1    <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					scan_q   <= '0;
					valid_s1 <= 1'b0;
					if (in_valid) begin
						if (in_data.cmd == CMD_FORMAT) begin
							used_q    <= '0;
							free_q    <= 9'(ENTRIES);
							mounted_q <= 1'b1;
						end
						state_q <= go_scan ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					scan_q   <= scan_end ? scan_q : scan_q + 1'b1;
					valid_s1 <= !scan_end && is_lookup;
					if (free_slot) begin
						used_q[scan_idx] <= 1'b1;
						free_q  <= free_q - 9'd1;
						clr_q   <= '0;
						state_q <= S_CLEAR;
					end else if (cmd_q == CMD_CREATE) begin
						if (scan_end) begin
							state_q <= S_DONE;
						end
					end else if (hit) begin
						if (cmd_q == CMD_DELETE) begin
							used_q[idx_s1] <= 1'b0;
							free_q  <= free_q + 9'd1;
							state_q <= S_DONE;
						end else if (cmd_q == CMD_READ && !off_big && !off_past) begin
							state_q <= S_RDWAIT;
						end else begin
							state_q <= S_DONE;
						end
					end else if (valid_s1 && last_s1) begin
						state_q <= S_DONE;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(FILE_BYTES - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx;
		if (state_q == S_IDLE && in_valid) begin
			cmd_q   <= in_data.cmd;
			name_q  <= in_data.file_name;
			off_q   <= in_data.byte_offset;
			wdata_q <= in_data.write_data;
			res_q.status     <= idle_status;
			res_q.read_data  <= 8'd0;
			res_q.free_count <= '0;
			res_q.used_count <= (in_data.cmd == CMD_INFO && mounted_q)
				? 9'(ENTRIES) - free_q : 9'd0;
		end
		if (free_slot) begin
			hit_idx_q    <= scan_idx;
			res_q.status <= STS_OK;
		end else if (state_q == S_SCAN && cmd_q == CMD_CREATE && scan_end) begin
			res_q.status <= STS_NO_FREE_ENTRY;
		end else if (hit) begin
			if (cmd_q == CMD_DELETE) begin
				res_q.status <= STS_OK;
			end else if (cmd_q == CMD_READ) begin
				res_q.status <= (off_big || off_past) ? STS_RANGE : STS_OK;
			end else begin
				res_q.status <= off_big ? STS_RANGE : STS_OK;
			end
		end else if (state_q == S_SCAN && is_lookup && valid_s1 && last_s1) begin
			res_q.status <= STS_NOT_FOUND;
		end
		if (state_q == S_RDWAIT) begin
			res_q.read_data <= dat_rd;
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_q <= '{status: res_q.status, read_data: res_q.read_data,
				free_count: free_q, used_count: res_q.used_count};
		end
	end

`ifndef ASSERT_OFF
	a_free_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		mounted_q |-> (32'($countones(used_q)) + 32'(free_q) == 32'(ENTRIES)))
		else $error("free count disagrees with used marks");

	a_ent_write_mounted: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> mounted_q)
		else $error("entry write while not mounted");

	a_rdwait_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDWAIT) |-> !dat_we && (cmd_q == CMD_READ))
		else $error("data write during read wait");

	a_clear_after_create: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (cmd_q == CMD_CREATE) && used_q[hit_idx_q])
		else $error("block clear for an entry that is not in use");
`endif

endmodule
